>>> rtl/euler_rotation_matrix_assert.svh
// assertion macros for the euler rotation matrix block
// used by the top level; needs no other file
`ifndef EULER_ROTATION_MATRIX_ASSERT_SVH
`define EULER_ROTATION_MATRIX_ASSERT_SVH
// implication checked on every rising edge outside reset
`define ERM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ERM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/erm_pkg.sv
// shared constants, arctan table and rounding helper for the rotation matrix block
// no dependencies
`timescale 1ns / 1ps
package erm_pkg;
    localparam int OutFracBitsDef  = 14;
    localparam int CordicStagesDef = 16;
    localparam int AngFull     = 23040;
    localparam int AngQuarter  = 5760;
    localparam int Ang3Quarter = 17280;
    localparam int TableLen    = 32;
    // sine and cosine width, q2.30 plus guard bit
    localparam int VW = 33;
    localparam int ZW = 32;
    localparam logic signed [VW-1:0] InvGain = 33'sd652032874;
    localparam logic signed [VW-1:0] OneQ30  = 33'sd1073741824;

    typedef logic signed [VW-1:0] t_q30;
    typedef logic signed [ZW-1:0] t_ang;

    function automatic t_ang atan_deg(input int i);
        t_ang r;
        case (i)
            0: r = 32'sd188743680;   1: r = 32'sd111421900;  2: r = 32'sd58872272;
            3: r = 32'sd29884485;    4: r = 32'sd15000234;   5: r = 32'sd7507429;
            6: r = 32'sd3754631;     7: r = 32'sd1877430;    8: r = 32'sd938729;
            9: r = 32'sd469366;     10: r = 32'sd234683;    11: r = 32'sd117342;
            12: r = 32'sd58671;     13: r = 32'sd29335;     14: r = 32'sd14668;
            15: r = 32'sd7334;      16: r = 32'sd3667;      17: r = 32'sd1833;
            18: r = 32'sd917;       19: r = 32'sd458;       20: r = 32'sd229;
            21: r = 32'sd115;       22: r = 32'sd57;        23: r = 32'sd29;
            24: r = 32'sd14;        25: r = 32'sd7;         26: r = 32'sd4;
            27: r = 32'sd2;         28: r = 32'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    // q2.30 product rounded half up
    function automatic t_q30 mul_q30(input t_q30 a, input t_q30 b);
        logic signed [2*VW-1:0] p;
        p = a * b + (2*VW)'(64'sd536870912);
        return t_q30'(p >>> 30);
    endfunction
endpackage

>>> rtl/erm_cordic.sv
// pipelined sine and cosine of one angle in 1/64 degree units
// depends on erm_pkg
`timescale 1ns / 1ps
module erm_cordic import erm_pkg::*; #(
    parameter int CORDIC_STAGES = CordicStagesDef
) (
    input  logic              i_clk,
    input  logic signed [15:0] i_angle,
    output t_q30              o_sin,
    output t_q30              o_cos
);
    localparam int N = CORDIC_STAGES;
    // reduction stage
    logic signed [15:0] n_r;
    logic signed [15:0] r_z0;
    logic               r_neg0;
    logic signed [16:0] n_a;
    logic signed [16:0] n_m;
    // 16-bit input spans less than two full turns either way, so compare and add/subtract
    always_comb begin
        n_a = 17'(i_angle);
        if (n_a >= 17'(AngFull)) n_m = n_a - 17'(AngFull);
        else if (n_a >= 0) n_m = n_a;
        else if (n_a >= -17'(AngFull)) n_m = n_a + 17'(AngFull);
        else n_m = n_a + 17'(2*AngFull);
        n_r = 16'(n_m);
    end
    always_ff @(posedge i_clk) begin
        if (n_r <= 16'(AngQuarter)) begin
            r_z0 <= n_r; r_neg0 <= 1'b0;
        end else if (n_r < 16'(Ang3Quarter)) begin
            r_z0 <= 16'(AngFull/2) - n_r; r_neg0 <= 1'b1;
        end else begin
            r_z0 <= n_r - 16'(AngFull); r_neg0 <= 1'b0;
        end
    end
    // cordic stages, one register per iteration
    t_q30 r_x [0:N];
    t_q30 r_y [0:N];
    t_ang r_z [0:N];
    logic r_neg [0:N];
    always_comb begin
        r_x[0] = InvGain;
        r_y[0] = '0;
        r_z[0] = t_ang'(r_z0) <<< 16;
        r_neg[0] = r_neg0;
    end
    for (genvar i = 0; i < N; i++) begin : g_st
        always_ff @(posedge i_clk) begin
            if (!r_z[i][ZW-1]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - atan_deg(i);
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + atan_deg(i);
            end
            r_neg[i+1] <= r_neg[i];
        end
    end
    // clamp and sign stage
    t_q30 n_cx, n_sy;
    always_comb begin
        n_cx = r_x[N];
        if (n_cx > OneQ30) n_cx = OneQ30;
        if (n_cx < -OneQ30) n_cx = -OneQ30;
        n_sy = r_y[N];
        if (n_sy > OneQ30) n_sy = OneQ30;
        if (n_sy < -OneQ30) n_sy = -OneQ30;
    end
    always_ff @(posedge i_clk) begin
        o_sin <= n_sy;
        o_cos <= r_neg[N] ? -n_cx : n_cx;
    end
endmodule

>>> rtl/euler_rotation_matrix.sv
// euler xyz rotation matrix top level: three cordic pipes and a product pipeline
// depends on erm_pkg, erm_cordic and euler_rotation_matrix_assert.svh
`timescale 1ns / 1ps
// takes one angle triple per clock (busy is always low) and returns the
// 3x3 matrix mx*my*mz in q1.OUT_FRAC_BITS; the result passes through the
// cordic pipe, three product stages and one output stage; o_valid marks
// each result for one cycle and the receiver cannot stall, so results
// must be taken when shown
module euler_rotation_matrix import erm_pkg::*; #(
    parameter int OUT_FRAC_BITS = OutFracBitsDef,
    parameter int CORDIC_STAGES = CordicStagesDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic signed [15:0] i_angle_x,
    input  logic signed [15:0] i_angle_y,
    input  logic signed [15:0] i_angle_z,
    output logic              o_valid,
    output logic signed [15:0] o_row0_col0, o_row0_col1, o_row0_col2,
    output logic signed [15:0] o_row1_col0, o_row1_col1, o_row1_col2,
    output logic signed [15:0] o_row2_col0, o_row2_col1, o_row2_col2
);
`include "euler_rotation_matrix_assert.svh"
    // the valid pipe spans the cordic pipe, three product stages and the output stage
    localparam int Lat = CORDIC_STAGES + 6;
    localparam int Sh  = 30 - OUT_FRAC_BITS;

    assign busy = 1'b0;

    // valid bits travel beside the data
    logic [Lat-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else r_vld <= {r_vld[Lat-2:0], start};
    end
    assign o_valid = r_vld[Lat-1];

    t_q30 sx, cx, sy, cy, sz, cz;
    erm_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cx (
        .i_clk(i_clk), .i_angle(i_angle_x), .o_sin(sx), .o_cos(cx));
    erm_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cy (
        .i_clk(i_clk), .i_angle(i_angle_y), .o_sin(sy), .o_cos(cy));
    erm_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cz (
        .i_clk(i_clk), .i_angle(i_angle_z), .o_sin(sz), .o_cos(cz));

    // product stage 1: sx*sy, cx*sy and carry the rest
    t_q30 r_sxsy, r_cxsy, r1_sx, r1_cx, r1_sy, r1_cy, r1_sz, r1_cz;
    always_ff @(posedge i_clk) begin
        r_sxsy <= mul_q30(sx, sy);
        r_cxsy <= mul_q30(cx, sy);
        r1_sx <= sx; r1_cx <= cx; r1_sy <= sy;
        r1_cy <= cy; r1_sz <= sz; r1_cz <= cz;
    end
    // product stage 2: all second-level products
    t_q30 r_p [0:11];
    t_q30 r2_sy;
    always_ff @(posedge i_clk) begin
        r_p[0]  <= mul_q30(r1_cy, r1_cz);
        r_p[1]  <= mul_q30(r1_cy, r1_sz);
        r_p[2]  <= mul_q30(r1_cx, r1_sz);
        r_p[3]  <= mul_q30(r_sxsy, r1_cz);
        r_p[4]  <= mul_q30(r_sxsy, r1_sz);
        r_p[5]  <= mul_q30(r1_cx, r1_cz);
        r_p[6]  <= mul_q30(r1_sx, r1_cy);
        r_p[7]  <= mul_q30(r_cxsy, r1_cz);
        r_p[8]  <= mul_q30(r1_sx, r1_sz);
        r_p[9]  <= mul_q30(r1_sx, r1_cz);
        r_p[10] <= mul_q30(r_cxsy, r1_sz);
        r_p[11] <= mul_q30(r1_cx, r1_cy);
        r2_sy <= r1_sy;
    end
    // stage 3: sums
    logic signed [VW:0] r_e [0:8];
    always_ff @(posedge i_clk) begin
        r_e[0] <= (VW+1)'(r_p[0]);
        r_e[1] <= -(VW+1)'(r_p[1]);
        r_e[2] <= -(VW+1)'(r2_sy);
        r_e[3] <= (VW+1)'(r_p[2]) - (VW+1)'(r_p[3]);
        r_e[4] <= (VW+1)'(r_p[4]) + (VW+1)'(r_p[5]);
        r_e[5] <= -(VW+1)'(r_p[6]);
        r_e[6] <= (VW+1)'(r_p[7]) + (VW+1)'(r_p[8]);
        r_e[7] <= (VW+1)'(r_p[9]) - (VW+1)'(r_p[10]);
        r_e[8] <= (VW+1)'(r_p[11]);
    end
    // stage 4: round, saturate, mask
    localparam logic signed [VW+1:0] Lim = (VW+2)'(64'sd1 <<< OUT_FRAC_BITS);
    localparam logic signed [VW+1:0] Half = (Sh == 0) ? '0 : (VW+2)'(64'sd1 <<< (Sh-1));
    logic [15:0] r_o [0:8];
    for (genvar k = 0; k < 9; k++) begin : g_out
        logic signed [VW+1:0] n_rd;
        always_comb begin
            n_rd = ((VW+2)'(r_e[k]) + Half) >>> Sh;
            if (n_rd > Lim) n_rd = Lim;
            if (n_rd < -Lim) n_rd = -Lim;
        end
        always_ff @(posedge i_clk) r_o[k] <= n_rd[15:0];
    end
    assign o_row0_col0 = r_o[0]; assign o_row0_col1 = r_o[1]; assign o_row0_col2 = r_o[2];
    assign o_row1_col0 = r_o[3]; assign o_row1_col1 = r_o[4]; assign o_row1_col2 = r_o[5];
    assign o_row2_col0 = r_o[6]; assign o_row2_col1 = r_o[7]; assign o_row2_col2 = r_o[8];

    // a start bit must enter the valid pipe, and its last stage must reach o_valid
    `ERM_ASSERT_NEXT(a_vld_enter, i_clk, i_rst_n, start, r_vld[0], "valid bit lost at entry")
    `ERM_ASSERT_NEXT(a_vld_shift, i_clk, i_rst_n, r_vld[Lat-2], o_valid, "valid bit lost in pipe")
    `ERM_ASSERT_IMPL(a_never_busy, i_clk, i_rst_n, 1'b1, !busy, "busy raised")
endmodule

>>> tb/sv/tb_top.sv
// self-checking bench for the euler xyz rotation matrix block
// depends on erm_pkg and the euler_rotation_matrix top level
`timescale 1ns / 1ps

// nine q1.14 entries, row-major, entry 0 in the low 16 bits
typedef logic [8:0][15:0] t_matrix;

class matrix_scoreboard;
    t_matrix pending[$];
    int      mismatches;

    // arctan(2^-i) in degrees with 22 fraction bits
    static const longint atan_tab[16] = '{188743680, 111421900, 58872272, 29884485,
        15000234, 7507429, 3754631, 1877430, 938729, 469366, 234683, 117342,
        58671, 29335, 14668, 7334};

    function new();
        mismatches = 0;
    endfunction

    static function longint qmul(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    static function longint sat_q30(longint v);
        if (v > (64'sd1 <<< 30)) return 64'sd1 <<< 30;
        if (v < -(64'sd1 <<< 30)) return -(64'sd1 <<< 30);
        return v;
    endfunction

    static function logic [15:0] to_q14(longint v);
        longint r;
        r = (v + (64'sd1 <<< 15)) >>> 16;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    // reduce, fold into +/-90 degrees, then rotate a 16-stage cordic
    static function void sine_cosine(input logic signed [15:0] ang, output longint s,
                                     output longint c);
        longint r, z, x, y, dx, dy;
        bit     flip;
        flip = 0;
        r = longint'(ang) % erm_pkg::AngFull;
        if (r < 0) r += erm_pkg::AngFull;
        if (r <= erm_pkg::AngQuarter) z = r;
        else if (r < erm_pkg::Ang3Quarter) begin
            z = erm_pkg::AngFull / 2 - r;
            flip = 1;
        end else z = r - erm_pkg::AngFull;
        z = z <<< 16;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        s = sat_q30(y);
        c = flip ? -sat_q30(x) : sat_q30(x);
    endfunction

    static function t_matrix rotation_matrix(logic signed [15:0] ax,
                                             logic signed [15:0] ay,
                                             logic signed [15:0] az);
        longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
        t_matrix m;
        sine_cosine(ax, sx, cx);
        sine_cosine(ay, sy, cy);
        sine_cosine(az, sz, cz);
        sxsy = qmul(sx, sy);
        cxsy = qmul(cx, sy);
        m[0] = to_q14(qmul(cy, cz));
        m[1] = to_q14(-qmul(cy, sz));
        m[2] = to_q14(-sy);
        m[3] = to_q14(qmul(cx, sz) - qmul(sxsy, cz));
        m[4] = to_q14(qmul(sxsy, sz) + qmul(cx, cz));
        m[5] = to_q14(-qmul(sx, cy));
        m[6] = to_q14(qmul(cxsy, cz) + qmul(sx, sz));
        m[7] = to_q14(qmul(sx, cz) - qmul(cxsy, sz));
        m[8] = to_q14(qmul(cx, cy));
        return m;
    endfunction

    function void note_input(logic signed [15:0] ax, logic signed [15:0] ay,
                             logic signed [15:0] az);
        pending.push_back(rotation_matrix(ax, ay, az));
    endfunction

    function void check_result(t_matrix got);
        t_matrix want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        want = pending.pop_front();
        for (int k = 0; k < 9; k++)
            if (want[k] !== got[k]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("entry r%0d c%0d: expected %h got %h", k / 3, k % 3,
                             want[k], got[k]);
            end
    endfunction
endclass

module tb_top;
    localparam int Latency   = 16 + 6;
    localparam int WatchLim  = 3000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    logic signed [15:0] i_angle_x = 0, i_angle_y = 0, i_angle_z = 0;
    logic o_valid;
    logic signed [15:0] o_row0_col0, o_row0_col1, o_row0_col2;
    logic signed [15:0] o_row1_col0, o_row1_col1, o_row1_col2;
    logic signed [15:0] o_row2_col0, o_row2_col1, o_row2_col2;

    matrix_scoreboard sb = new();
    int idle_cycles = 0;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    euler_rotation_matrix u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_angle_x(i_angle_x), .i_angle_y(i_angle_y), .i_angle_z(i_angle_z),
        .o_valid(o_valid),
        .o_row0_col0(o_row0_col0), .o_row0_col1(o_row0_col1), .o_row0_col2(o_row0_col2),
        .o_row1_col0(o_row1_col0), .o_row1_col1(o_row1_col1), .o_row1_col2(o_row1_col2),
        .o_row2_col0(o_row2_col0), .o_row2_col1(o_row2_col1), .o_row2_col2(o_row2_col2)
    );

    // results cannot be held off, so every strobed cycle is a transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result({o_row2_col2, o_row2_col1, o_row2_col0,
                             o_row1_col2, o_row1_col1, o_row1_col0,
                             o_row0_col2, o_row0_col1, o_row0_col0});
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLim) begin
            $display("FAIL");
            $finish;
        end
    end

    // one angle transaction; idle_pct is the sender's chance of a gap per cycle
    task automatic send_angles(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start     <= 1;
        i_angle_x <= ax;
        i_angle_y <= ay;
        i_angle_z <= az;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_input(ax, ay, az);
    endtask

    // angles near the quadrant edges and wrap points, in 1/64 degree
    function automatic logic [15:0] edge_angle();
        int base;
        case ($urandom_range(7))
            0: base = 0;
            1: base = 5760;
            2: base = 11520;
            3: base = 17280;
            4: base = 23040;
            5: base = -5760;
            6: base = -23040;
            default: base = 32767;
        endcase
        return 16'(base + $urandom_range(4) - 2);
    endfunction

    function automatic logic [15:0] rand_angle();
        return ($urandom_range(3) == 0) ? edge_angle() : 16'($urandom);
    endfunction

    // pause the sender until the pipeline has drained
    task automatic drain();
        start <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] dir_angles[16];
        int          phase_idle[4];
        dir_angles = '{16'h0000, 16'h8000, 16'h7fff, 16'hffff, 16'd5760, 16'd5761,
                       16'd11520, 16'd17279, 16'd17280, 16'd17281, 16'd23039,
                       16'd23040, 16'hE980, 16'hA600, 16'd1, 16'h5555};
        phase_idle = '{0, 66, 0, 18};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, quadrant boundaries, wrap points
        for (int k = 0; k < 16; k++)
            send_angles(dir_angles[k], dir_angles[(k + 5) % 16],
                        dir_angles[(k + 11) % 16], 0);
        send_angles(16'h8000, 16'h8000, 16'h8000, 0);
        send_angles(16'h7fff, 16'h7fff, 16'h7fff, 0);
        send_angles(16'd5760, 16'd5760, 16'd5760, 0);
        send_angles(16'd11520, 16'd17280, 16'd23040, 0);
        drain();

        for (int p = 0; p < 4; p++) begin
            for (int n = 0; n < 335; n++)
                send_angles(rand_angle(), rand_angle(), rand_angle(), phase_idle[p]);
            drain();
        end

        repeat (Latency + 4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
